[hdl/ffpa_pkg.sv]
// Shared types and constants for the first-fit page run allocator.
// No dependencies; every other file imports this package.
package ffpa_pkg;

  localparam int ADDR_W     = 48;
  localparam int LIMIT_W    = 9;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Slot map codes
  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_USED = 2'd1;
  localparam logic [1:0] SLOT_END  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [8:0]        page_count;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] run_address;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    clr;
    logic    load;
    logic    start;
    logic    step;
    logic    mark;
    logic    respond;
    status_t status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic req_kind;
    logic req_bad;
    logic hit;
    logic done;
    logic mark_done;
    logic out_busy;
  } dp_sts_t;

endpackage

[hdl/first_fit_page_run_allocator_top.sv]
// Top level of the first-fit page run allocator.
// Depends on ffpa_pkg, ffpa_regs, ffpa_ctrl and ffpa_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transaction is one
//   request, allocate (kind 0, page_count pages) or free (kind 1, address).
//   Result channel (out_valid / out_stall / out_data): exactly one
//   transaction per request, with status and the run start address.
//   Configuration port (cfg_*): base_address at byte 0, slot_limit at byte 8;
//   write only while the block is idle.
// Timing:
//   One request at a time. The slot map is a single-port-write memory with a
//   registered read, walked one slot per cycle. An allocate scans for a free run
//   and then marks its page_count slots; a free walks from its slot to the run
//   end. A bad request is answered without a scan. The scan is bounded by the
//   active limit.
// Reset:
//   rst_n (synchronous) starts a clearing pass that marks every slot unused;
//   in_stall stays high during it. Registers are taken.
// Stalling:
//   The result sits in an output register; a new request is accepted while it
//   waits. Hold the next result until the receiver takes the previous one.
module first_fit_page_run_allocator_top
  import ffpa_pkg::*;
#(
  parameter int MAP_DEPTH  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [ADDR_W-1:0]  base_address;
  logic [LIMIT_W-1:0] slot_limit;
  ctrl_cmd_t          cmd;
  dp_sts_t            sts;

  // Register file: base address and slot limit
  ffpa_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .base_address (base_address),
    .slot_limit   (slot_limit)
  );

  // Sequence each request: check, walk the map, mark, answer
  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Slot map and result register
  ffpa_datapath #(
    .MAP_DEPTH  (MAP_DEPTH),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .base_address (base_address),
    .slot_limit   (slot_limit),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall)
  );

endmodule

[hdl/ffpa_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on ffpa_pkg.
module ffpa_regs
  import ffpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [ADDR_W-1:0]     base_address,
  output logic [LIMIT_W-1:0]    slot_limit
);

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic [ADDR_W-1:0]  base_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               wr_en;
  logic               reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= LIMIT_W'(256);
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE:  base_r  <= cfg_pwdata[ADDR_W-1:0];
        REG_LIMIT: limit_r <= cfg_pwdata[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE:  cfg_prdata = CFG_DATA_W'(base_r);
      REG_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign base_address = base_r;
  assign slot_limit   = limit_r;

endmodule

[hdl/ffpa_datapath.sv]
// Datapath: slot map memory, scan and mark counters, request and result registers.
// Depends on ffpa_pkg; driven by ffpa_ctrl through ctrl_cmd_t.
module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int MAP_DEPTH  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  input  in_item_t           in_data,
  input  logic [ADDR_W-1:0]  base_address,
  input  logic [LIMIT_W-1:0] slot_limit,
  output logic               out_valid,
  output out_item_t          out_data,
  input  logic               out_stall
);

  localparam int IDX_W = $clog2(MAP_DEPTH);
  localparam int LIM_W = $clog2(MAP_DEPTH + 1);
  localparam int CNT_W = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;

  logic [1:0]        map_mem [MAP_DEPTH];
  logic [1:0]        map_q_r;
  in_item_t          req_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  chk_idx_r;
  logic [CNT_W-1:0]  run_r;
  logic [CNT_W-1:0]  mark_idx_r;
  logic [CNT_W-1:0]  last_r;
  logic [CNT_W-1:0]  start_r;
  logic              pend_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [CNT_W-1:0]  lim;
  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] slot_full;
  logic              free_bad;
  logic [CNT_W-1:0]  count_c;
  logic              issue;
  logic              hit;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [1:0]        wr_data;
  logic [ADDR_W-1:0] run_addr;

  // Active limit: smaller of the register and the map depth
  always_comb begin
    if (CNT_W'(slot_limit) > CNT_W'(MAP_DEPTH)) begin
      lim = CNT_W'(MAP_DEPTH);
    end else begin
      lim = CNT_W'(slot_limit);
    end
  end

  assign diff      = {1'b0, req_r.address} - {1'b0, base_address};
  assign slot_full = diff[ADDR_W-1:0] >> PAGE_SHIFT;
  assign free_bad  = diff[ADDR_W] || (slot_full >= ADDR_W'(lim));
  assign count_c   = CNT_W'(req_r.page_count);
  assign issue     = cmd.step && (rd_idx_r < lim);
  assign hit       = pend_r && (req_r.kind == KIND_ALLOC) && (map_q_r == SLOT_FREE)
                     && ((run_r + CNT_W'(1)) == count_c);

  assign sts.clr_done  = (clr_idx_r == IDX_W'(MAP_DEPTH - 1));
  assign sts.req_kind  = req_r.kind;
  assign sts.req_bad   = (req_r.kind == KIND_ALLOC) ? (req_r.page_count == '0) : free_bad;
  assign sts.hit       = hit;
  assign sts.done      = (pend_r && (req_r.kind == KIND_FREE) && (map_q_r == SLOT_END))
                         || (!pend_r && (rd_idx_r >= lim));
  assign sts.mark_done = (mark_idx_r == last_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  // Single write port: clearing sweep, run marking, or release during a free walk
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_r;
    wr_data = SLOT_FREE;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (cmd.mark) begin
      wr_en   = 1'b1;
      wr_addr = mark_idx_r[IDX_W-1:0];
      wr_data = (mark_idx_r == last_r) ? SLOT_END : SLOT_USED;
    end else if (cmd.step && pend_r && (req_r.kind == KIND_FREE)) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      map_q_r <= map_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign run_addr = base_address + (ADDR_W'(start_r) << PAGE_SHIFT);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      pend_r <= issue;
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.start) begin
      rd_idx_r <= (req_r.kind == KIND_FREE) ? slot_full[CNT_W-1:0] : '0;
      run_r    <= '0;
    end else if (cmd.step) begin
      if (issue) begin
        rd_idx_r  <= rd_idx_r + CNT_W'(1);
        chk_idx_r <= rd_idx_r;
      end
      if (pend_r && (req_r.kind == KIND_ALLOC)) begin
        run_r <= (map_q_r == SLOT_FREE) ? run_r + CNT_W'(1) : '0;
      end
    end
    if (cmd.step && hit) begin
      mark_idx_r <= chk_idx_r + CNT_W'(1) - count_c;
      start_r    <= chk_idx_r + CNT_W'(1) - count_c;
      last_r     <= chk_idx_r;
    end else if (cmd.mark) begin
      mark_idx_r <= mark_idx_r + CNT_W'(1);
    end
    if (cmd.respond) begin
      out_data_r.status      <= cmd.status;
      out_data_r.run_address <= ((cmd.status == ST_OK) && (req_r.kind == KIND_ALLOC))
                                ? run_addr : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> !(out_valid_r && out_stall))
    else $error("result register loaded while a transaction is still held");

  a_mark_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (mark_idx_r <= last_r) && (last_r < lim))
    else $error("run marking past the run end");

  a_read_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (chk_idx_r < lim))
    else $error("slot read beyond the active limit");

endmodule

[hdl/ffpa_ctrl.sv]
// Controller state machine for the allocator: clear sweep, check, scan, mark, respond.
// Depends on ffpa_pkg; commands ffpa_datapath.
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output ctrl_cmd_t cmd,
  input  dp_sts_t   sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cmd         = '0;
    cmd.status  = status_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.req_bad) begin
          status_nxt = ST_BAD;
          state_nxt  = S_RESP;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          status_nxt = ST_OK;
          state_nxt  = S_MARK;
        end else if (sts.done) begin
          status_nxt = (sts.req_kind == KIND_FREE) ? ST_OK : ST_NOSPACE;
          state_nxt  = S_RESP;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  a_clear_first: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR))
    else $error("reset did not start the map clearing sweep");

  a_hit_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && sts.hit |-> (sts.req_kind == KIND_ALLOC))
    else $error("run found during a free walk");

endmodule
